// ----- design/saa_pkg.sv -----
// Shared constants, status codes and controller command type for the
// short address allocator. No dependencies.
package saa_pkg;

    localparam int ADDR_COUNT  = 256;
    localparam int CNT_W       = $clog2(ADDR_COUNT);
    localparam int QUEUE_DEPTH = 256;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam int ADDR_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int LIMIT_W     = 17;
    localparam int OUT_TDATA_W = 16;

    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NONE_FREE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FREED_ZERO   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_QUEUE_FULL   = 3'd4;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;

endpackage

// ----- design/saa_ctrl.sv -----
// Controller for the short address allocator: request sequencing and
// output valid handling. Depends on saa_pkg.
module saa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output saa_pkg::cmd_t cmd
);
    import saa_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic m_tvalid_reg;
    logic m_tvalid_next;

    assign s_tready    = (state_reg == S_IDLE);
    assign cmd.capture = s_tvalid && s_tready;
    // the result register frees up in the same cycle it is taken
    assign cmd.execute = (state_reg == S_EXEC) && (!m_tvalid_reg || m_tready);
    assign m_tvalid    = m_tvalid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.execute)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.execute)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_exec_shows_word: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> m_tvalid)
        else $error("result word not presented after execute");

    a_capture_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_EXEC))
        else $error("accepted word did not start execution");

    a_stall_holds_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EXEC) && m_tvalid_reg && !m_tready) |=>
        ((state_reg == S_EXEC) && m_tvalid_reg))
        else $error("execution left while result register was blocked");

endmodule

// ----- design/saa_datapath.sv -----
// Datapath for the short address allocator: fresh address counter,
// free-list FIFO memory and pointers, result register. Depends on saa_pkg.
module saa_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  saa_pkg::cmd_t                    cmd,
    input  logic                             in_kind,
    input  logic [saa_pkg::ADDR_W-1:0]       in_addr,
    output logic [saa_pkg::OUT_TDATA_W-1:0]  out_data
);
    import saa_pkg::*;

    logic [ADDR_W-1:0]   fifo_mem [QUEUE_DEPTH];
    logic [ADDR_W-1:0]   rd_data_reg;

    logic                kind_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [CNT_W-1:0]    fresh_reg;
    logic [CNT_W-1:0]    fresh_next;
    logic [QPTR_W-1:0]   head_reg;
    logic [QPTR_W-1:0]   head_next;
    logic [QPTR_W-1:0]   tail_reg;
    logic [QPTR_W-1:0]   tail_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic [OUT_TDATA_W-1:0] out_reg;

    logic                fresh_avail;
    logic [CNT_W-1:0]    fresh_inc;
    logic                queue_empty;
    logic                queue_full;
    logic                addr_high;
    logic                wr_en;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   granted;

    assign fresh_inc   = fresh_reg + 1'b1;
    assign fresh_avail = (fresh_reg != CNT_W'(ADDR_COUNT - 1));
    assign queue_empty = (count_reg == '0);
    assign queue_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign addr_high   = (LIMIT_W'(addr_reg) >= LIMIT_W'(ADDR_COUNT));

    always_comb
    begin
        status     = ST_OK;
        granted    = '0;
        fresh_next = fresh_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        if (kind_reg == KIND_ALLOC)
        begin
            if (fresh_avail)
            begin
                fresh_next = fresh_inc;
                granted    = ADDR_W'(fresh_inc);
            end
            else if (queue_empty)
            begin
                status = ST_NONE_FREE;
            end
            else
            begin
                granted    = rd_data_reg;
                head_next  = head_reg + 1'b1;
                count_next = count_reg - 1'b1;
            end
        end
        else if (addr_reg == '0)
        begin
            status = ST_FREED_ZERO;
        end
        else if (addr_high)
        begin
            status = ST_OUT_OF_RANGE;
        end
        else if (queue_full)
        begin
            status = ST_QUEUE_FULL;
        end
        else
        begin
            wr_en      = 1'b1;
            tail_next  = tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
    end

    // head entry is re-read every cycle; writes only land when a word retires
    always_ff @(posedge clk)
    begin
        if (cmd.execute && wr_en)
        begin
            fifo_mem[tail_reg] <= addr_reg;
        end
        rd_data_reg <= fifo_mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= in_kind;
            addr_reg <= in_addr;
        end
        if (cmd.execute)
        begin
            out_reg <= OUT_TDATA_W'({granted, status});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            fresh_reg <= fresh_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign out_data = out_reg;

endmodule

// ----- design/short_address_allocator_top.sv -----
// Short address allocator: each input word is an allocate request or a free
// of an address; one result word comes back per request. Allocation hands out
// fresh addresses 1 .. ADDR_COUNT-1 in order, then the oldest freed address
// from a 256-entry FIFO, and reports "none free" when that is empty. A free
// rejects zero, addresses of ADDR_COUNT or more, and a full FIFO, in that
// order; double frees are not detected. Each request is accepted in the idle
// state and carried out in the execute state, which leaves room for the
// registered read of the FIFO memory, so the block takes no new word until the last one has executed.
// The result sits in an output register and a new request is accepted while it waits.
// Depends on saa_pkg, saa_ctrl and saa_datapath.
module short_address_allocator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [saa_pkg::ADDR_W-1:0]          s_tdata,  // [7:0] free_addr
    input  logic                                s_tuser,  // [0] kind
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [saa_pkg::OUT_TDATA_W-1:0]     m_tdata   // [2:0] status,
                                                          // [10:3] granted_addr,
                                                          // [15:11] zero
);
    import saa_pkg::*;

    cmd_t cmd;

    saa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    saa_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_kind  (s_tuser),
        .in_addr  (s_tdata),
        .out_data (m_tdata)
    );

endmodule
